### src/lro_pkg.sv
// Shared constants and types for the linear RGB to Oklab converter.
package lro_pkg;

    // Fraction bits of the matrix coefficients.
    localparam int COEF_FRAC = 28;

    typedef logic signed [31:0] coef_mat_t [9];

    // Decimal coefficient scaled by 1e10, rounded to nearest at 28 fraction bits.
    function automatic logic signed [31:0] qc(input longint d);
        longint q;
        q = (d * 64'sd268435456 + 64'sd5000000000) / 64'sd10000000000;
        return q[31:0];
    endfunction

    // Linear RGB to LMS cone space, row major.
    localparam coef_mat_t TO_LMS = '{
        qc(64'sd4122214708), qc(64'sd5363325363), qc(64'sd514459929),
        qc(64'sd2119034982), qc(64'sd6806995451), qc(64'sd1073969566),
        qc(64'sd883024619),  qc(64'sd2817188376), qc(64'sd6299787005)
    };

    // Cube-rooted LMS to Oklab L, a, b, row major.
    localparam coef_mat_t TO_LAB = '{
        qc(64'sd2104542553),  qc(64'sd7936177850),   -qc(64'sd40720468),
        qc(64'sd19779984951), -qc(64'sd24285922050), qc(64'sd4505937099),
        qc(64'sd259040371),   qc(64'sd7827717662),   -qc(64'sd8086757660)
    };

endpackage

### src/lro_mat3.sv
// Three-stage 3x3 constant matrix multiply with round half away from zero.
module lro_mat3 #(
    parameter int IW = 16,
    parameter lro_pkg::coef_mat_t COEF = lro_pkg::TO_LMS
) (
    input  logic                 clk,
    input  logic [2:0]           en,
    input  logic signed [IW-1:0] x [3],
    output logic [IW+5:0]        mag [3],
    output logic                 neg [3]
);

    localparam int PW = IW + 32;
    localparam int SW = IW + 34;
    localparam int CF = lro_pkg::COEF_FRAC;
    localparam logic [SW-1:0] RND  = SW'(1) << (CF - 1);
    localparam logic [SW-1:0] RND1 = RND + SW'(1);

    logic signed [PW-1:0] prod_reg [9];
    logic signed [SW-1:0] acc_reg [3];
    logic [SW-1:0]        rnd_next [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            if (en[0])
            begin
                prod_reg[k] <= PW'(x[k % 3]) * PW'(COEF[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[1])
            begin
                acc_reg[i] <= SW'(prod_reg[3 * i]) + SW'(prod_reg[3 * i + 1])
                              + SW'(prod_reg[3 * i + 2]);
            end
        end
    end

    // Magnitude plus half an output step; negative sums fold the negation into the add.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (acc_reg[i][SW-1])
            begin
                rnd_next[i] = ~acc_reg[i] + RND1;
            end
            else
            begin
                rnd_next[i] = acc_reg[i] + RND;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[2])
            begin
                mag[i] <= rnd_next[i][SW-1:CF];
                neg[i] <= acc_reg[i][SW-1];
            end
        end
    end

endmodule

### src/lro_cbrt_cell.sv
// One digit cell of the pipelined cube root: resolves one root bit per cell.
module lro_cbrt_cell #(
    parameter int NR = 16
) (
    input  logic              clk,
    input  logic              en,
    input  logic              neg_in,
    input  logic [NR-1:0]     r_in,
    input  logic [2*NR-1:0]   s_in,
    input  logic [2*NR+5:0]   rem_in,
    input  logic [3*NR-1:0]   t_in,
    output logic              neg_out,
    output logic [NR-1:0]     r_out,
    output logic [2*NR-1:0]   s_out,
    output logic [2*NR+5:0]   rem_out,
    output logic [3*NR-1:0]   t_out
);

    localparam int RMW = 2 * NR + 6;
    localparam int SQW = 2 * NR;

    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           take;

    // The step from (2r)^3 to (2r+1)^3 is 12 r^2 + 6 r + 1; s holds r^2.
    always_comb
    begin
        rem_sh = {rem_in[RMW-4:0], t_in[3*NR-1 -: 3]};
        trial  = RMW'({s_in, 3'b000}) + RMW'({s_in, 2'b00})
                 + RMW'({r_in, 2'b00}) + RMW'({r_in, 1'b0}) + RMW'(1);
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_out <= neg_in;
            r_out   <= {r_in[NR-2:0], take};
            t_out   <= {t_in[3*NR-4:0], 3'b000};
            if (take)
            begin
                rem_out <= rem_sh - trial;
                s_out   <= SQW'({s_in, 2'b00}) + SQW'({r_in, 2'b00}) + SQW'(1);
            end
            else
            begin
                rem_out <= rem_sh;
                s_out   <= SQW'({s_in, 2'b00});
            end
        end
    end

endmodule

### src/linear_rgb_to_oklab.sv
// Top level of the linear RGB to Oklab converter.
//
// One linear RGB pixel enters per request on the s_axis channel and one Oklab
// pixel leaves per request on the m_axis channel, in the same order. Samples
// are signed with SAMPLE_WIDTH-2 fraction bits (Q2.14 at the default width).
// The pixel goes through an RGB to LMS matrix (three stages), a signed cube
// root built as a chain of SAMPLE_WIDTH digit cells that each settle one root
// bit, one stage that rounds and signs the root, an LMS to Lab matrix
// (three stages) and a final saturation stage that is the output register.
// The block takes one pixel in every cycle unless the receiver stalls with every
// stage full; the length of the digit-cell chain sets the pipeline depth.
// Every stage holds a valid bit and moves whenever the stage after it is empty
// or moving, so bubbles close up and input is still taken while a finished
// pixel waits at the output. When the receiver stalls with every stage full,
// s_axis_tready drops until m_axis_tready returns.
// Reset empties the pipeline: all valid bits clear and no pixel is lost or
// invented afterwards. Nothing is kept from one pixel to the next.
module linear_rgb_to_oklab #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0 up: red, green, blue, then zero fill.
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0 up: lightness, green_red, blue_yellow, then zero fill.
    output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int FR  = W - 2;
    localparam int NR  = W;              // root bits before the final rounding
    localparam int RMW = 2 * NR + 6;
    localparam int DW  = ((3 * W + 7) / 8) * 8;
    localparam int NS  = NR + 8;         // pipeline stages
    localparam int S_CELL = 3;
    localparam int S_ROOT = NR + 3;
    localparam int S_LAB  = NR + 4;
    localparam int S_OUT  = NR + 7;
    localparam int OW1 = W + 6;
    localparam int OW2 = W + 7;
    localparam logic [OW2-1:0] NEG_LIM = OW2'(1) << (W - 1);
    localparam logic [OW2-1:0] POS_LIM = NEG_LIM - OW2'(1);
    localparam logic [W-1:0]   POS_MAX = POS_LIM[W-1:0];
    localparam logic [W-1:0]   NEG_MAX = NEG_LIM[W-1:0];

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    // Stage i moves when it is empty or when stage i+1 moves.
    assign en[NS-1] = !valid_reg[NS-1] || m_axis_tready;
    genvar gi;
    generate
        for (gi = 0; gi < NS - 1; gi++)
        begin : g_en
            assign en[gi] = !valid_reg[gi] || en[gi+1];
        end
    endgenerate

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[NS-1];

    // RGB to LMS.
    logic signed [W-1:0] rgb [3];
    logic [OW1-1:0]      lms_mag [3];
    logic                lms_neg [3];

    assign rgb[0] = s_axis_tdata[W-1:0];
    assign rgb[1] = s_axis_tdata[2*W-1:W];
    assign rgb[2] = s_axis_tdata[3*W-1:2*W];

    lro_mat3 #(
        .IW   (W),
        .COEF (lro_pkg::TO_LMS)
    ) u_to_lms (
        .clk (clk),
        .en  (en[2:0]),
        .x   (rgb),
        .mag (lms_mag),
        .neg (lms_neg)
    );

    // Cube root chains, one per cone. The radicand carries 2*FR+3 extra bits so
    // that the integer root, plus one and halved, is the rounded root.
    logic [NR-1:0]   r_w   [3][NR+1];
    logic [2*NR-1:0] s_w   [3][NR+1];
    logic [RMW-1:0]  rem_w [3][NR+1];
    logic [3*NR-1:0] t_w   [3][NR+1];
    logic            neg_w [3][NR+1];

    genvar gl, gk;
    generate
        for (gl = 0; gl < 3; gl++)
        begin : g_lane
            assign r_w[gl][0]   = '0;
            assign s_w[gl][0]   = '0;
            assign rem_w[gl][0] = '0;
            assign neg_w[gl][0] = lms_neg[gl];
            assign t_w[gl][0]   = {lms_mag[gl][FR+2:0], (2 * FR + 3)'(0)};
            for (gk = 0; gk < NR; gk++)
            begin : g_cell
                lro_cbrt_cell #(
                    .NR (NR)
                ) u_cell (
                    .clk     (clk),
                    .en      (en[S_CELL+gk]),
                    .neg_in  (neg_w[gl][gk]),
                    .r_in    (r_w[gl][gk]),
                    .s_in    (s_w[gl][gk]),
                    .rem_in  (rem_w[gl][gk]),
                    .t_in    (t_w[gl][gk]),
                    .neg_out (neg_w[gl][gk+1]),
                    .r_out   (r_w[gl][gk+1]),
                    .s_out   (s_w[gl][gk+1]),
                    .rem_out (rem_w[gl][gk+1]),
                    .t_out   (t_w[gl][gk+1])
                );
            end
        end
    endgenerate

    // Rounded, signed roots.
    logic signed [W:0] root_reg [3];
    logic [W:0]        r_inc [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_inc[i] = {1'b0, r_w[i][NR]} + (W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[S_ROOT])
            begin
                if (neg_w[i][NR])
                begin
                    root_reg[i] <= -$signed({1'b0, r_inc[i][W:1]});
                end
                else
                begin
                    root_reg[i] <= $signed({1'b0, r_inc[i][W:1]});
                end
            end
        end
    end

    // LMS roots to Lab.
    logic [OW2-1:0] lab_mag [3];
    logic           lab_neg [3];

    lro_mat3 #(
        .IW   (W + 1),
        .COEF (lro_pkg::TO_LAB)
    ) u_to_lab (
        .clk (clk),
        .en  (en[S_LAB+2:S_LAB]),
        .x   (root_reg),
        .mag (lab_mag),
        .neg (lab_neg)
    );

    // Saturation into the output register.
    logic [W-1:0] lab_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (en[S_OUT])
            begin
                if (lab_neg[i])
                begin
                    if (lab_mag[i] > NEG_LIM)
                    begin
                        lab_reg[i] <= NEG_MAX;
                    end
                    else
                    begin
                        lab_reg[i] <= ~lab_mag[i][W-1:0] + W'(1);
                    end
                end
                else
                begin
                    if (lab_mag[i] > POS_LIM)
                    begin
                        lab_reg[i] <= POS_MAX;
                    end
                    else
                    begin
                        lab_reg[i] <= lab_mag[i][W-1:0];
                    end
                end
            end
        end
    end

    assign m_axis_tdata = DW'({lab_reg[2], lab_reg[1], lab_reg[0]});

endmodule

### src/lro_check.sv
// Port-level checker for the linear RGB to Oklab converter, bound to the top level.
module lro_check #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int NS = SAMPLE_WIDTH + 8;
    localparam int CW = $clog2(NS + 2);

    logic [CW-1:0] count_reg;
    logic          in_req;
    logic          out_req;

    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;

    // Requests inside the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_req && !out_req)
        begin
            count_reg <= count_reg + CW'(1);
        end
        else if (out_req && !in_req)
        begin
            count_reg <= count_reg - CW'(1);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output request changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> count_reg != '0)
        else $error("output request without a pending input");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(NS))
        else $error("more requests in flight than pipeline stages");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage is empty");

endmodule

bind linear_rgb_to_oklab lro_check #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lro_check (.*);

### sim/tb_linear_rgb_to_oklab.sv
// Testbench for the linear RGB to Oklab converter: random and corner pixels checked against a predictor.
module tb_linear_rgb_to_oklab;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = 16;
    localparam int FB = SW - 2;
    localparam int DW = ((3 * SW + 7) / 8) * 8;
    localparam int LATENCY = SW + 8;
    localparam int HOLD_CYCLES = 8 * LATENCY;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [SW-1:0] lightness;
        logic signed [SW-1:0] green_red;
        logic signed [SW-1:0] blue_yellow;
    } lab_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;

    lab_t lab_queue[$];
    int errors = 0;
    longint cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #4 clk = ~clk;

    linear_rgb_to_oklab #(.SAMPLE_WIDTH(SW)) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Round a value with 28 extra fraction bits back to the sample fraction,
    // half away from zero.
    function automatic longint drop_coef_frac(input longint x);
        longint mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (64'sd1 <<< (lro_pkg::COEF_FRAC - 1))) >>> lro_pkg::COEF_FRAC;
        return (x < 0) ? -mag : mag;
    endfunction

    // Signed cube root at FB fraction bits: the largest y with
    // (2y-1)^3 <= 8 * |x| * 2^(2*FB), which rounds to nearest.
    function automatic longint cube_root_fixed(input longint x);
        logic [127:0] target;
        logic [127:0] odd_cube;
        logic [63:0] y;
        logic [63:0] trial;
        longint mag;
        mag = (x < 0) ? -x : x;
        target = 128'(mag) << (2 * FB + 3);
        y = '0;
        for (int b = 30; b >= 0; b--)
        begin
            trial = y | (64'd1 << b);
            odd_cube = 128'(2 * trial - 1) * 128'(2 * trial - 1) * 128'(2 * trial - 1);
            if (odd_cube <= target)
                y = trial;
        end
        return (x < 0) ? -longint'(y) : longint'(y);
    endfunction

    function automatic logic signed [SW-1:0] clamp_sample(input longint v);
        longint top;
        top = (64'sd1 <<< (SW - 1)) - 1;
        if (v > top)
            return top[SW-1:0];
        if (v < -top - 1)
            return {1'b1, {(SW - 1){1'b0}}};
        return v[SW-1:0];
    endfunction

    function automatic lab_t predict_oklab(input logic signed [SW-1:0] r,
                                           input logic signed [SW-1:0] g,
                                           input logic signed [SW-1:0] b);
        longint chan[3];
        longint cone_root[3];
        longint acc;
        logic signed [SW-1:0] res[3];
        lab_t lab;
        chan[0] = r;
        chan[1] = g;
        chan[2] = b;
        for (int i = 0; i < 3; i++)
        begin
            acc = longint'(lro_pkg::TO_LMS[3*i]) * chan[0]
                + longint'(lro_pkg::TO_LMS[3*i+1]) * chan[1]
                + longint'(lro_pkg::TO_LMS[3*i+2]) * chan[2];
            cone_root[i] = cube_root_fixed(drop_coef_frac(acc));
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = longint'(lro_pkg::TO_LAB[3*i]) * cone_root[0]
                + longint'(lro_pkg::TO_LAB[3*i+1]) * cone_root[1]
                + longint'(lro_pkg::TO_LAB[3*i+2]) * cone_root[2];
            res[i] = clamp_sample(drop_coef_frac(acc));
        end
        lab.lightness = res[0];
        lab.green_red = res[1];
        lab.blue_yellow = res[2];
        return lab;
    endfunction

    // Offer one pixel after an optional gap; the prediction is queued when the
    // request is accepted. Valid stays high into the next pixel when there is no gap.
    task automatic send_pixel(input logic signed [SW-1:0] r, input logic signed [SW-1:0] g,
                              input logic signed [SW-1:0] b, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= DW'({b, g, r});
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lab_queue.push_back(predict_oklab(r, g, b));
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SW-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SW'($urandom_range(0, 31));
            3: return -SW'($urandom_range(0, 31));
            4: return SW'($urandom_range(0, 16384));
            default: return SW'($urandom());
        endcase
    endfunction

    // Stop offering and wait until every predicted result has been checked.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (lab_queue.size() != 0)
            @(posedge clk);
    endtask

    // Corners: zero, full scale, white, single primaries and sign flips.
    task automatic test_corners();
        logic signed [SW-1:0] vals[6];
        vals = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh4000, 16'shC000, 16'sh0001};
        send_pixel('0, '0, '0, 0);
        send_pixel(16'sh4000, 16'sh4000, 16'sh4000, 0);
        send_pixel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_pixel(16'sh8000, 16'sh8000, 16'sh8000, 1);
        send_pixel(16'sh4000, '0, '0, 0);
        send_pixel('0, 16'sh4000, '0, 0);
        send_pixel('0, '0, 16'sh4000, 2);
        send_pixel(16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
        send_pixel(16'sh8000, 16'sh7FFF, 16'sh8000, 0);
        send_pixel(16'sh0001, 16'shFFFF, '0, 0);
        for (int i = 0; i < 12; i++)
            send_pixel(vals[$urandom_range(0, 5)], vals[$urandom_range(0, 5)],
                       vals[$urandom_range(0, 5)], 0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pixel(random_sample(), random_sample(), random_sample(), random_gap());
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall
    // its input while pixels keep being offered.
    task automatic test_backpressure();
        hold_req++;
        test_random(80);
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        wait_drained();
        test_backpressure();
        test_random(1550);
        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) < 75);
    end

    // Checker: each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        lab_t want;
        lab_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[SW-1:0], m_axis_tdata[2*SW-1:SW], m_axis_tdata[3*SW-1:2*SW]};
            if (lab_queue.size() == 0)
            begin
                $error("result with no pixel outstanding: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = lab_queue.pop_front();
                if (got.lightness !== want.lightness)
                begin
                    $error("lightness expected %0d actual %0d", want.lightness, got.lightness);
                    errors++;
                end
                if (got.green_red !== want.green_red)
                begin
                    $error("green_red expected %0d actual %0d", want.green_red, got.green_red);
                    errors++;
                end
                if (got.blue_yellow !== want.blue_yellow)
                begin
                    $error("blue_yellow expected %0d actual %0d", want.blue_yellow,
                           got.blue_yellow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end
endmodule
